// ----- rtl/sbqmix_pkg.sv -----
// ----------------------------------------------------------------------------
// sbqmix_pkg
// Shared types and constants of the stereo biquad cascade with dry/wet mix.
// ----------------------------------------------------------------------------
package sbqmix_pkg;

    localparam int SAMPLE_W = 24;
    localparam int WORD_W   = 32;
    localparam int OPND_W   = 33;   // multiplier operand, signed
    localparam int PROD_W   = 66;
    localparam int ACC_W    = 68;
    localparam int LEN_W    = 16;
    localparam int QUOT_W   = 34;   // signed quotient

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_BEGIN  = 2'd2;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;
    localparam int         SLOTS   = 5;

    localparam logic CFG_PREAMP   = 1'b0;
    localparam logic CFG_SECTIONS = 1'b1;

    typedef struct packed {
        logic                     mul_en;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
        logic                     acc_clr;
        logic                     acc_en;
        logic                     acc_neg;
    } mac_req_t;

    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] dividend;
        logic [LEN_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/sbqmix_mac.sv -----
// ----------------------------------------------------------------------------
// sbqmix_mac
// Shared 33x33 signed multiplier with registered product and a tap
// accumulator that adds floor(+/-product / 4).
// ----------------------------------------------------------------------------
module sbqmix_mac
(
    input  logic                                   clk,
    input  sbqmix_pkg::mac_req_t                   req,
    output logic signed [sbqmix_pkg::PROD_W-1:0]   prod,
    output logic signed [sbqmix_pkg::ACC_W-1:0]    acc
);

    logic signed [sbqmix_pkg::PROD_W-1:0] prod_reg;
    logic signed [sbqmix_pkg::ACC_W-1:0]  acc_reg;
    logic signed [sbqmix_pkg::ACC_W-1:0]  prod_ext;
    logic signed [sbqmix_pkg::ACC_W-1:0]  term;

    assign prod_ext = sbqmix_pkg::ACC_W'(prod_reg);
    assign term     = (req.acc_neg ? -prod_ext : prod_ext) >>> 2;

    always_ff @(posedge clk)
    begin
        if (req.mul_en)
        begin
            prod_reg <= req.a * req.b;
        end
        if (req.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (req.acc_en)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ----- rtl/sbqmix_div.sv -----
// ----------------------------------------------------------------------------
// sbqmix_div
// Restoring divider, one quotient bit per cycle: signed 33-bit dividend by
// unsigned 16-bit divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module sbqmix_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbqmix_pkg::div_req_t req,
    output sbqmix_pkg::div_rsp_t rsp
);

    localparam int MAG_W = sbqmix_pkg::OPND_W;
    localparam int REM_W = sbqmix_pkg::LEN_W + 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [MAG_W-1:0]              quo_reg;
    logic                          neg_reg;
    logic [sbqmix_pkg::LEN_W-1:0]  dvs_reg;

    logic [REM_W-1:0]              rem_shift;
    logic [REM_W:0]                trial;
    logic                          take;
    logic signed [sbqmix_pkg::QUOT_W-1:0] mag_ext;

    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[MAG_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign take      = !trial[REM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[MAG_W-1];
            quo_reg <= req.dividend[MAG_W-1] ? MAG_W'(-req.dividend) : MAG_W'(req.dividend);
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[REM_W-1:0] : rem_shift;
            quo_reg <= {quo_reg[MAG_W-2:0], take};
        end
    end

    assign mag_ext      = sbqmix_pkg::QUOT_W'(quo_reg);
    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -mag_ext : mag_ext;

endmodule

// ----- rtl/stereo_biquad_cascade_mix_top.sv -----
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_mix_top
// Preamp, cascade of direct-form-I biquads and ramped dry/wet blend.
// ----------------------------------------------------------------------------
// A sample beat runs the preamp, each active section in turn and the blend;
// every product goes through one shared 33x33 multiplier, five taps per
// section plus the preamp and the blend. A valid coefficient load is written
// when accepted, and a begin-block beat with nonzero length runs the bit-serial
// divider. After reset the history memory is cleared one row per cycle,
// all CHANNELS*MAX_SECTIONS rows, while s_tready stays low; configuration
// writes are taken anytime. A finished result sits in the output register,
// so the next beat can be taken while it waits.
module stereo_biquad_cascade_mix_top
#(
    parameter int MAX_SECTIONS = 16,
    parameter int CHANNELS     = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    // [0] channel, [1] first_of_channel, [25:2] sample_in, [29:26] coeff_section,
    // [32:30] coeff_slot, [64:33] coeff_value, [81:65] mix_target,
    // [97:82] block_length, [103:98] zero
    input  logic [103:0]  s_tdata,
    input  logic [1:0]    s_tuser,   // [1:0] opcode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,   // [23:0] sample_out
    output logic          m_tuser    // [0] out_channel
);

    localparam int HIST_ROWS = CHANNELS * MAX_SECTIONS;
    localparam int HW        = (HIST_ROWS > 1) ? $clog2(HIST_ROWS) : 1;
    localparam int COEF_N    = MAX_SECTIONS * sbqmix_pkg::SLOTS;
    localparam int CW        = (COEF_N > 1) ? $clog2(COEF_N) : 1;
    localparam int KW        = $clog2(MAX_SECTIONS + 1);
    localparam int RW        = $clog2(HIST_ROWS + 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_PRE_MUL = 4'd2;
    localparam logic [3:0] S_PRE_RES = 4'd3;
    localparam logic [3:0] S_SEC_RD  = 4'd4;
    localparam logic [3:0] S_TAP     = 4'd5;
    localparam logic [3:0] S_SEC_END = 4'd6;
    localparam logic [3:0] S_MIX_MUL = 4'd7;
    localparam logic [3:0] S_MIX_RES = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;

    localparam logic [2:0] TAP_LAST = 3'd6;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (x < -68'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // input fields
    logic [1:0]         in_op;
    logic               in_chan;
    logic               in_first;
    logic signed [23:0] in_sample;
    logic [3:0]         in_sec;
    logic [2:0]         in_slot;
    logic signed [31:0] in_coef;
    logic [16:0]        in_target;
    logic [15:0]        in_len;

    assign in_op     = s_tuser;
    assign in_chan   = s_tdata[0];
    assign in_first  = s_tdata[1];
    assign in_sample = s_tdata[25:2];
    assign in_sec    = s_tdata[29:26];
    assign in_slot   = s_tdata[32:30];
    assign in_coef   = s_tdata[64:33];
    assign in_target = s_tdata[81:65];
    assign in_len    = s_tdata[97:82];

    // control and state
    logic [3:0]         state_reg, state_next;
    logic [RW-1:0]      clr_reg;
    logic [KW-1:0]      sec_reg;
    logic [KW-1:0]      n_reg;
    logic [2:0]         tap_reg;
    logic               chan_reg;
    logic signed [23:0] dry_reg;
    logic signed [31:0] v_reg;
    logic [31:0]        preamp_reg;
    logic [4:0]         count_reg;
    logic signed [31:0] stored_mix_reg;
    logic signed [31:0] ramp_start_reg;
    logic signed [31:0] ramp_step_reg;
    logic signed [31:0] ramp_run_reg;
    logic               m_valid_reg;
    logic [23:0]        m_data_reg;
    logic               m_user_reg;

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // memories
    logic signed [31:0]  coef_mem [COEF_N];
    logic signed [31:0]  coef_q;
    logic [CW-1:0]       coef_raddr;
    logic [127:0]        hist_mem [HIST_ROWS];
    logic [127:0]        hist_q;
    logic [HW-1:0]       hist_row;
    logic                hist_we;
    logic [HW-1:0]       hist_waddr;
    logic [127:0]        hist_wdata;

    logic signed [31:0]  h_x1, h_x2, h_y1, h_y2;
    assign h_x1 = hist_q[127:96];
    assign h_x2 = hist_q[95:64];
    assign h_y1 = hist_q[63:32];
    assign h_y2 = hist_q[31:0];

    logic load_ok;
    logic [CW-1:0] load_addr;
    assign load_ok   = (int'(in_sec) < MAX_SECTIONS) && (in_slot < 3'(sbqmix_pkg::SLOTS));
    assign load_addr = CW'(int'(in_sec) * sbqmix_pkg::SLOTS + int'(in_slot));

    assign coef_raddr = CW'(int'(sec_reg) * sbqmix_pkg::SLOTS
                           + ((tap_reg < 3'(sbqmix_pkg::SLOTS)) ? int'(tap_reg) : 0));
    assign hist_row   = CW > 0 ? HW'(((CHANNELS > 1) ? int'(chan_reg) : 0) * MAX_SECTIONS
                                     + int'(sec_reg)) : '0;

    always_ff @(posedge clk)
    begin
        if (accept && in_op == sbqmix_pkg::OP_LOAD && load_ok)
        begin
            coef_mem[load_addr] <= in_coef;
        end
        coef_q <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q <= hist_mem[hist_row];
    end

    // shared units
    sbqmix_pkg::mac_req_t mac_req;
    logic signed [sbqmix_pkg::PROD_W-1:0] mac_prod;
    logic signed [sbqmix_pkg::ACC_W-1:0]  mac_acc;
    sbqmix_pkg::div_req_t div_req;
    sbqmix_pkg::div_rsp_t div_rsp;

    sbqmix_mac u_mac
    (
        .clk  (clk),
        .req  (mac_req),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    sbqmix_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic signed [31:0] target_ext;
    assign target_ext = signed'({1'b0, in_target, 14'd0});

    assign div_req.start    = accept && in_op == sbqmix_pkg::OP_BEGIN && in_len != '0;
    assign div_req.dividend = 33'(target_ext) - 33'(stored_mix_reg);
    assign div_req.divisor  = in_len;

    // datapath results
    logic signed [31:0] pre_v;
    logic signed [31:0] sec_y;
    logic signed [sbqmix_pkg::PROD_W-1:0] wet;
    logic signed [sbqmix_pkg::ACC_W-1:0]  mixed;
    logic signed [23:0] mix_out;
    logic signed [31:0] ramp_next;
    logic signed [2:0]  tap_m1;

    assign pre_v = sat32(68'((mac_prod + 66'sd2097152) >>> 22));
    assign sec_y = sat32((mac_acc + 68'sd8388608) >>> 24);
    assign wet   = (mac_prod + 66'sd536870912) >>> 30;
    assign mixed = 68'(wet) + 68'(dry_reg);
    assign mix_out = (mixed > 68'sd8388607) ? 24'sh7FFFFF :
                     (mixed < -68'sd8388608) ? 24'sh800000 : mixed[23:0];
    assign ramp_next = sat32(68'(ramp_run_reg) + 68'(ramp_step_reg));
    assign tap_m1 = signed'(tap_reg - 3'd1);

    always_comb
    begin
        mac_req         = '0;
        hist_we         = 1'b0;
        hist_waddr      = hist_row;
        hist_wdata      = {v_reg, h_x1, sec_y, h_y1};
        state_next      = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = HW'(clr_reg);
                hist_wdata = '0;
                if (clr_reg == RW'(HIST_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_op == sbqmix_pkg::OP_SAMPLE)
                    begin
                        state_next = S_PRE_MUL;
                    end
                    else if (div_req.start)
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_PRE_MUL:
            begin
                mac_req.mul_en = 1'b1;
                mac_req.a      = 33'(dry_reg);
                mac_req.b      = signed'({1'b0, preamp_reg});
                state_next     = S_PRE_RES;
            end
            S_PRE_RES:
            begin
                state_next = (n_reg == '0) ? S_MIX_MUL : S_SEC_RD;
            end
            S_SEC_RD:
            begin
                mac_req.acc_clr = 1'b1;
                state_next      = S_TAP;
            end
            S_TAP:
            begin
                // product of tap t-1 issued, tap t-2 accumulated
                if (tap_reg >= 3'd1 && tap_reg <= 3'd5)
                begin
                    mac_req.mul_en = 1'b1;
                    mac_req.a      = 33'(coef_q);
                    unique case (tap_m1)
                        3'(sbqmix_pkg::SLOT_B0): mac_req.b = 33'(v_reg);
                        3'(sbqmix_pkg::SLOT_B1): mac_req.b = 33'(h_x1);
                        3'(sbqmix_pkg::SLOT_B2): mac_req.b = 33'(h_x2);
                        3'(sbqmix_pkg::SLOT_A1): mac_req.b = 33'(h_y1);
                        default:                 mac_req.b = 33'(h_y2);
                    endcase
                end
                if (tap_reg >= 3'd2)
                begin
                    mac_req.acc_en  = 1'b1;
                    mac_req.acc_neg = (tap_reg >= 3'd5);
                end
                if (tap_reg == TAP_LAST)
                begin
                    state_next = S_SEC_END;
                end
            end
            S_SEC_END:
            begin
                hist_we    = 1'b1;
                state_next = (sec_reg + 1'b1 == n_reg) ? S_MIX_MUL : S_SEC_RD;
            end
            S_MIX_MUL:
            begin
                mac_req.mul_en = 1'b1;
                mac_req.a      = 33'(ramp_run_reg);
                mac_req.b      = 33'(v_reg) - 33'(dry_reg);
                state_next     = S_MIX_RES;
            end
            S_MIX_RES:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            sec_reg        <= '0;
            n_reg          <= '0;
            tap_reg        <= '0;
            preamp_reg     <= 32'd4194304;
            count_reg      <= '0;
            stored_mix_reg <= '0;
            ramp_start_reg <= '0;
            ramp_step_reg  <= '0;
            ramp_run_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sbqmix_pkg::CFG_PREAMP:   preamp_reg <= cfg_data;
                    sbqmix_pkg::CFG_SECTIONS: count_reg  <= cfg_data[4:0];
                    default:                  count_reg  <= count_reg;
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept)
            begin
                sec_reg <= '0;
                n_reg   <= (int'(count_reg) > MAX_SECTIONS) ? KW'(MAX_SECTIONS) : KW'(count_reg);
                if (in_op == sbqmix_pkg::OP_SAMPLE && in_first)
                begin
                    ramp_run_reg <= ramp_start_reg;
                end
                if (div_req.start)
                begin
                    ramp_start_reg <= stored_mix_reg;
                    stored_mix_reg <= target_ext;
                end
            end
            if (state_reg == S_SEC_RD)
            begin
                tap_reg <= '0;
            end
            else if (state_reg == S_TAP)
            begin
                tap_reg <= tap_reg + 1'b1;
            end
            if (state_reg == S_SEC_END)
            begin
                sec_reg <= sec_reg + 1'b1;
            end
            if (state_reg == S_DIV && div_rsp.done)
            begin
                ramp_step_reg <= sat32(68'(div_rsp.quotient));
            end
            // a new result may replace the one leaving in the same cycle
            if (state_reg == S_MIX_RES && state_next == S_IDLE)
            begin
                m_valid_reg  <= 1'b1;
                ramp_run_reg <= ramp_next;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_reg <= in_chan;
            dry_reg  <= in_sample;
        end
        if (state_reg == S_PRE_RES)
        begin
            v_reg <= pre_v;
        end
        else if (state_reg == S_SEC_END)
        begin
            v_reg <= sec_y;
        end
        if (state_reg == S_MIX_RES && state_next == S_IDLE)
        begin
            m_data_reg <= mix_out;
            m_user_reg <= chan_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_div_only_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == S_IDLE))
        else $error("divider started outside idle");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("beat accepted during history clear");

    a_section_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAP || state_reg == S_SEC_END) |-> (sec_reg < n_reg))
        else $error("section index past active count");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX_RES && !m_tvalid) |=> m_tvalid)
        else $error("finished sample not presented");
`endif

endmodule

// ----- verif/stereo_biquad_cascade_mix_checker.sv -----
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_mix_checker
// Watches the config port and both stream channels, keeps its own model of
// preamp, biquad cascade and ramped mix, and compares every result beat
// in order against the predicted one.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade_mix_checker
#(
    parameter int MAX_SECTIONS = 16,
    parameter int CHANNELS     = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [103:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [23:0]   m_tdata,
    input  logic          m_tuser,
    output int            error_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST = MAX_SECTIONS * CHANNELS;

    typedef struct {
        logic        chan;
        logic [23:0] smp;
    } audio_out_t;

    audio_out_t  expected_audio[$];

    int          coef[MAX_SECTIONS * sbqmix_pkg::SLOTS];
    int          xd1[HIST];
    int          xd2[HIST];
    int          yd1[HIST];
    int          yd2[HIST];
    int          mix_store;
    int          ramp_base;
    int          ramp_inc;
    int          ramp_now;
    logic [31:0] gain;
    logic [4:0]  nsec;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    function automatic logic [23:0] eq_sample(longint dry, int ch);
        int     n;
        int     v;
        int     y;
        int     h;
        int     k;
        int     base;
        longint acc;
        longint wet;
        longint mixed;
        n = (nsec > MAX_SECTIONS) ? MAX_SECTIONS : int'(nsec);
        v = sat32((dry * longint'(gain) + (64'sd1 <<< 21)) >>> 22);
        for (k = 0; k < n; k++)
        begin
            h = ch * MAX_SECTIONS + k;
            base = k * sbqmix_pkg::SLOTS;
            acc = (longint'(coef[base+sbqmix_pkg::SLOT_B0]) * longint'(v)) >>> 2;
            acc += (longint'(coef[base+sbqmix_pkg::SLOT_B1]) * longint'(xd1[h])) >>> 2;
            acc += (longint'(coef[base+sbqmix_pkg::SLOT_B2]) * longint'(xd2[h])) >>> 2;
            acc += (-(longint'(coef[base+sbqmix_pkg::SLOT_A1]) * longint'(yd1[h]))) >>> 2;
            acc += (-(longint'(coef[base+sbqmix_pkg::SLOT_A2]) * longint'(yd2[h]))) >>> 2;
            y = sat32((acc + (64'sd1 <<< 23)) >>> 24);
            xd2[h] = xd1[h];
            xd1[h] = v;
            yd2[h] = yd1[h];
            yd1[h] = y;
            v = y;
        end
        wet = (longint'(ramp_now) * (longint'(v) - dry) + (64'sd1 <<< 29)) >>> 30;
        mixed = dry + wet;
        if (mixed > 64'sd8388607)
            mixed = 64'sd8388607;
        if (mixed < -64'sd8388608)
            mixed = -64'sd8388608;
        return mixed[23:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint     target;
        audio_out_t got;
        audio_out_t want;
        if (!rst_n)
        begin
            foreach (coef[i]) coef[i] = 0;
            foreach (xd1[i])
            begin
                xd1[i] = 0;
                xd2[i] = 0;
                yd1[i] = 0;
                yd2[i] = 0;
            end
            mix_store = 0;
            ramp_base = 0;
            ramp_inc = 0;
            ramp_now = 0;
            gain = 32'd4194304;
            nsec = 5'd0;
            error_count = 0;
            expected_audio.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sbqmix_pkg::CFG_PREAMP)
                    gain = cfg_data;
                else
                    nsec = cfg_data[4:0];
            end
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    sbqmix_pkg::OP_LOAD:
                        if (s_tdata[32:30] < sbqmix_pkg::SLOTS)
                            coef[int'(s_tdata[29:26]) * sbqmix_pkg::SLOTS
                                 + int'(s_tdata[32:30])] = int'(s_tdata[64:33]);
                    sbqmix_pkg::OP_BEGIN:
                        if (s_tdata[97:82] != 0)
                        begin
                            target = longint'(s_tdata[81:65]) <<< 14;
                            ramp_base = mix_store;
                            ramp_inc = sat32((target - longint'(mix_store)) /
                                             longint'(s_tdata[97:82]));
                            mix_store = int'(target);
                        end
                    sbqmix_pkg::OP_SAMPLE:
                    begin
                        if (s_tdata[1])
                            ramp_now = ramp_base;
                        want.chan = s_tdata[0];
                        want.smp = eq_sample(longint'($signed(s_tdata[25:2])),
                                             int'(s_tdata[0]) % CHANNELS);
                        ramp_now = sat32(longint'(ramp_now) + longint'(ramp_inc));
                        expected_audio.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.chan = m_tuser;
                got.smp = m_tdata;
                if (expected_audio.size() == 0)
                begin
                    $error("unexpected result beat: out_channel %0d sample_out %0d",
                           got.chan, $signed(got.smp));
                    error_count++;
                end
                else
                begin
                    want = expected_audio.pop_front();
                    if (got.chan !== want.chan)
                    begin
                        $error("out_channel: expected %0d actual %0d", want.chan, got.chan);
                        error_count++;
                    end
                    if (got.smp !== want.smp)
                    begin
                        $error("sample_out: expected %0d actual %0d",
                               $signed(want.smp), $signed(got.smp));
                        error_count++;
                    end
                end
            end
        end
        pending = expected_audio.size();
    end

endmodule

// ----- verif/stereo_biquad_cascade_mix_top_test.sv -----
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_mix_top_test
// Drives coefficient loads, ramped blocks of stereo samples and noise beats
// through several gain/section settings and handshake pressure profiles;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module stereo_biquad_cascade_mix_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int MAX_SECTIONS_TB = 16;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic          cfg_index = 1'b0;
    logic [31:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [103:0]  s_tdata = '0;
    logic [1:0]    s_tuser = sbqmix_pkg::OP_SAMPLE;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [23:0]   m_tdata;
    logic          m_tuser;
    int            error_count;
    int            pending;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles = 0;
    int            beats_sent;

    stereo_biquad_cascade_mix_top u_dut (.*);

    stereo_biquad_cascade_mix_checker u_chk (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stereo_biquad_cascade_mix_top_test: done, errors");
            $finish;
        end
    end

    function automatic logic [103:0] beat(logic ch, logic first, logic [23:0] smp,
                                          logic [3:0] sec, logic [2:0] slot,
                                          logic [31:0] val, logic [16:0] tgt,
                                          logic [15:0] len);
        return {6'b0, len, tgt, val, slot, sec, smp, first, ch};
    endfunction

    task automatic send(logic [1:0] op, logic [103:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= op;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_sample(logic ch, logic first, logic [23:0] smp);
        send(sbqmix_pkg::OP_SAMPLE, beat(ch, first, smp, '0, '0, '0, '0, '0));
    endtask

    task automatic send_load(logic [3:0] sec, logic [2:0] slot, logic [31:0] val);
        send(sbqmix_pkg::OP_LOAD, beat(1'b0, 1'b0, '0, sec, slot, val, '0, '0));
    endtask

    task automatic send_begin(logic [16:0] tgt, logic [15:0] len);
        send(sbqmix_pkg::OP_BEGIN, beat(1'b0, 1'b0, '0, '0, '0, '0, tgt, len));
    endtask

    // b0 near unity, feedback kept small so the cascade mostly stays in range
    function automatic logic [31:0] tame_coeff(logic [2:0] slot);
        if ($urandom_range(9) == 0)
            return $urandom;
        if (slot == sbqmix_pkg::SLOT_B0)
            return 32'sd67108864 + $signed(32'($urandom_range(0, 16777216))) - 32'sd8388608;
        return $signed(32'($urandom_range(0, 8388608))) - 32'sd4194304;
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(9))
            0: return 24'h7fffff;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic idle_and_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic ramp_block();
        logic [16:0] tgt;
        logic [15:0] len;
        int          per_ch;
        case ($urandom_range(7))
            0: tgt = 17'd0;
            1: tgt = 17'd65536;
            default: tgt = 17'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(11))
            0: len = 16'd65535;
            1: len = 16'd0;
            default: len = 16'($urandom_range(1, 8));
        endcase
        send_begin(tgt, len);
        // sometimes run past the block end to let the ramp keep stepping
        per_ch = (len == 0 || len > 10) ? $urandom_range(1, 4) : len + $urandom_range(0, 2);
        for (int i = 0; i < per_ch; i++)
        begin
            send_sample(1'b0, i == 0, rand_sample());
            send_sample(1'b1, i == 0, rand_sample());
        end
    endtask

    task automatic noise_beat();
        logic [103:0] d;
        d = 104'({$urandom, $urandom, $urandom, $urandom});
        d[103:98] = '0;
        send(2'($urandom), d);
    endtask

    initial
    begin
        logic [31:0] gains[8];
        logic [31:0] counts[8];
        int          quota;
        gains  = '{32'd4194304, 32'd0, 32'hffffffff, 32'd4194304,
                   32'd2097152, 32'd8388608, 32'd4194304, 32'd0};
        counts = '{32'd1, 32'd16, 32'd2, 32'd31, 32'd0, 32'd3, 32'd17, 32'd5};
        beats_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no sections yet: dry path, ramp control, ignored beats
        send_sample(1'b0, 1'b1, 24'h7fffff);
        send_sample(1'b1, 1'b1, 24'h800000);
        send_begin(17'd65536, 16'd0);
        send_sample(1'b0, 1'b0, 24'h000001);
        send_begin(17'd65536, 16'd1);
        send_sample(1'b0, 1'b1, 24'h7fffff);
        send_sample(1'b1, 1'b1, 24'h800000);
        send_sample(1'b0, 1'b0, 24'h400000);
        send_begin(17'd0, 16'd65535);
        send_sample(1'b1, 1'b1, 24'h123456);
        send(2'd3, beat(1'b1, 1'b1, 24'hffffff, 4'hf, 3'd7, '1, '1, '1));
        send_load(4'd15, 3'd5, 32'h7fffffff);
        send_load(4'd0, 3'd7, 32'h80000000);
        send_sample(1'b1, 1'b0, 24'h000000);
        for (int s = 0; s < MAX_SECTIONS_TB; s++)
            for (int k = 0; k < sbqmix_pkg::SLOTS; k++)
                send_load(4'(s), 3'(k), tame_coeff(3'(k)));
        send_load(4'd15, sbqmix_pkg::SLOT_A2, 32'h80000000);
        send_load(4'd14, sbqmix_pkg::SLOT_B1, 32'h7fffffff);
        idle_and_drain();

        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_reg(sbqmix_pkg::CFG_PREAMP, (seg == 7) ? $urandom : gains[seg]);
            write_reg(sbqmix_pkg::CFG_SECTIONS, counts[seg]);
            quota = beats_sent + 100;
            while (beats_sent < quota)
            begin
                case ($urandom_range(19))
                    0, 1: noise_beat();
                    2:    send_load(4'($urandom), 3'($urandom_range(0, 7)), tame_coeff(3'($urandom)));
                    default: ramp_block();
                endcase
            end
            idle_and_drain();
        end

        if (error_count == 0 && pending == 0)
            $display("stereo_biquad_cascade_mix_top_test: done, clean");
        else
            $display("stereo_biquad_cascade_mix_top_test: done, errors");
        $finish;
    end

endmodule
